>>> design/oest_pkg.sv
package oest_pkg;

    localparam int MAX_ENTRIES_DEF = 32;
    localparam int NAME_BYTES      = 12;
    localparam int CAP_W           = 6;
    localparam int POS_W           = 5;
    localparam int CNT_W           = 6;
    localparam int NAME_LEN_W      = 4;
    localparam logic [CAP_W-1:0] CAP_RESET = 6'd30;

    // request payload, in-field order low to high
    localparam int IN_W  = 1 + 5 + 16 + 16 + 32 + 32 + 8 + 8 + 64 + 32 + 32;
    localparam int IN_TW = ((IN_W + 7) / 8) * 8;
    // result payload
    localparam int OUT_W  = 3 + 5 + 6 + 16 + 16 + 32 + 32 + 8 + 4 + 64 + 32 + 32;
    localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;

    // stored entry: sid, user, lat, lon, batt, len, name, stamp
    localparam int ENT_W = 16 + 16 + 32 + 32 + 8 + 4 + 96 + 32;

    typedef enum logic [2:0] {
        OC_UPDATED   = 3'd0,
        OC_APPENDED  = 3'd1,
        OC_EVICTED   = 3'd2,
        OC_READ_OK   = 3'd3,
        OC_READ_NONE = 3'd4
    } t_outcome;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_WRITE,
        ST_READ,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic start_scan;
        logic scan_step;
        logic start_shift;
        logic shift_step;
        logic do_write;
        logic do_read;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic is_read;
        logic scan_done;
        logic found;
        logic need_evict;
        logic shift_done;
    } t_stat;

    // keep bytes up to the first zero within the declared length
    function automatic logic [NAME_LEN_W+95:0] clean_name(
        input logic [95:0] raw, input logic [7:0] decl);
        logic [95:0] nm;
        logic [NAME_LEN_W-1:0] len;
        logic go;
        nm  = '0;
        len = '0;
        go  = 1'b1;
        for (int k = 0; k < NAME_BYTES; k++) begin
            if (go && (8'(k) < decl) && (raw[8*k +: 8] != 8'd0)) begin
                nm[8*k +: 8] = raw[8*k +: 8];
                len = NAME_LEN_W'(k + 1);
            end else begin
                go = 1'b0;
            end
        end
        return {len, nm};
    endfunction

endpackage

>>> design/oest_ram.sv
module oest_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> design/oest_ctrl.sv
module oest_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    output logic            o_req_ready,
    output logic            o_res_valid,
    input  logic            i_res_ready,
    input  oest_pkg::t_stat i_stat,
    output oest_pkg::t_cmd  o_cmd
);
    import oest_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        o_res_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.start_scan = 1'b1;
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_stat.is_read) begin
                    o_cmd.do_read = 1'b1;
                    n_state = ST_READ;
                end else if (i_stat.scan_done) begin
                    if (!i_stat.found && i_stat.need_evict) begin
                        o_cmd.start_shift = 1'b1;
                        n_state = ST_SHIFT;
                    end else begin
                        n_state = ST_WRITE;
                    end
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            ST_SHIFT: begin
                if (i_stat.shift_done) begin
                    n_state = ST_WRITE;
                end else begin
                    o_cmd.shift_step = 1'b1;
                end
            end
            ST_WRITE: begin
                o_cmd.do_write = 1'b1;
                n_state = ST_READ;
            end
            ST_READ: begin
                o_cmd.load_out = 1'b1;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule

>>> design/oest_dp.sv
module oest_dp #(
    parameter int MAX_ENTRIES = oest_pkg::MAX_ENTRIES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [oest_pkg::CAP_W-1:0]  i_cfg_data,
    input  logic [oest_pkg::IN_TW-1:0]  i_req,
    input  logic                        i_req_take,
    input  oest_pkg::t_cmd              i_cmd,
    output oest_pkg::t_stat             o_stat,
    output logic [oest_pkg::OUT_TW-1:0] o_res
);
    import oest_pkg::*;

    localparam int AW  = $clog2(MAX_ENTRIES);
    localparam int FCW = $clog2(MAX_ENTRIES + 1);

    logic [CAP_W-1:0] r_cap;
    logic [FCW-1:0]   r_fill;
    logic [IN_W-1:0]  r_req;
    logic [FCW-1:0]   r_idx;
    logic             r_rd_pend;
    logic             r_found;
    logic [AW-1:0]    r_slot;
    logic [AW-1:0]    r_old;
    logic [31:0]      r_old_ts;
    logic [AW-1:0]    r_sh;
    logic             r_sh_pend;
    logic             r_evict;
    logic [OUT_W-1:0] r_out;

    // request fields
    logic        q_op;
    logic [4:0]  q_pos;
    logic [15:0] q_sid, q_user;
    logic [31:0] q_lat, q_lon, q_now, q_nhi;
    logic [7:0]  q_bat, q_nlen;
    logic [63:0] q_nlo;
    assign {q_now, q_nhi, q_nlo, q_nlen, q_bat, q_lon, q_lat, q_user, q_sid, q_pos, q_op}
        = r_req;

    logic [FCW-1:0] eff_cap;
    always_comb begin
        if (r_cap == '0) eff_cap = FCW'(1);
        else if (32'(r_cap) > 32'(MAX_ENTRIES)) eff_cap = FCW'(MAX_ENTRIES);
        else eff_cap = FCW'(r_cap);
    end

    // memory ports
    logic            ram_we;
    logic [AW-1:0]   ram_wa, ram_ra;
    logic [ENT_W-1:0] ram_wd, ram_rd;

    oest_ram #(.WIDTH(ENT_W), .DEPTH(MAX_ENTRIES)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_wa),
        .i_wdata(ram_wd),
        .i_raddr(ram_ra),
        .o_rdata(ram_rd)
    );

    logic [15:0] rd_sid;
    logic [31:0] rd_ts;
    assign rd_sid = ram_rd[ENT_W-1 -: 16];
    assign rd_ts  = ram_rd[31:0];

    logic [NAME_LEN_W+95:0] nm;
    assign nm = clean_name({q_nhi, q_nlo}, q_nlen);

    // entry as written by this update
    logic [ENT_W-1:0] ent_new;
    assign ent_new = {q_sid, q_user, q_lat, q_lon, q_bat, nm, q_now};

    logic [AW-1:0] wr_slot;
    assign wr_slot = r_found ? r_slot : AW'(r_fill - FCW'(r_evict));

    // slot of the finished update; an append always lands at the new top
    logic [AW-1:0] done_slot;
    assign done_slot = r_found ? r_slot : AW'(r_fill - FCW'(1));

    // the scan reads entry r_idx each cycle; its data arrives in the next cycle
    logic scan_end;
    assign scan_end = (r_idx >= r_fill) || (32'(r_idx) >= 32'(MAX_ENTRIES));

    always_comb begin
        ram_we = 1'b0;
        ram_wa = wr_slot;
        ram_wd = ent_new;
        ram_ra = r_idx[AW-1:0];
        // shift reads run two entries ahead of the write address; each write takes the entry one above
        if (i_cmd.start_shift) begin
            ram_ra = AW'(r_old + AW'(1));
        end
        if (i_cmd.shift_step) begin
            ram_ra = AW'(r_sh + AW'(2));
        end
        if (i_cmd.do_read) begin
            ram_ra = q_pos[AW-1:0];
        end
        if (i_cmd.do_write) begin
            ram_we = 1'b1;
        end
        if (i_cmd.shift_step && r_sh_pend) begin
            ram_we = 1'b1;
            ram_wa = r_sh;
            ram_wd = ram_rd;
        end
    end

    assign o_stat.is_read    = q_op;
    assign o_stat.scan_done  = !r_rd_pend && (r_found || scan_end);
    assign o_stat.found      = r_found;
    assign o_stat.need_evict = (r_fill >= eff_cap) && (r_fill != '0);
    assign o_stat.shift_done = r_sh_pend && (32'(r_sh) + 1 >= 32'(r_fill));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap  <= CAP_RESET;
            r_fill <= '0;
        end else begin
            if (i_cfg_we) r_cap <= i_cfg_data;
            if (i_cmd.do_write && !r_found) begin
                if (!r_evict && 32'(r_fill) < 32'(MAX_ENTRIES)) r_fill <= r_fill + FCW'(1);
            end
        end
        if (i_req_take) begin
            r_req <= i_req[IN_W-1:0];
        end
        // linear match scan with oldest-stamp tracking
        if (i_cmd.start_scan) begin
            r_idx     <= '0;
            r_rd_pend <= 1'b0;
            r_found   <= 1'b0;
            r_evict   <= 1'b0;
            r_old     <= '0;
        end else if (i_cmd.scan_step) begin
            if (r_rd_pend) begin
                if (rd_sid == q_sid) begin
                    r_found <= 1'b1;
                    r_slot  <= AW'(r_idx - FCW'(1));
                end
                if (r_idx == FCW'(1) || rd_ts < r_old_ts) begin
                    r_old    <= AW'(r_idx - FCW'(1));
                    r_old_ts <= rd_ts;
                end
            end
            if (!scan_end && !(r_rd_pend && rd_sid == q_sid)) begin
                r_idx     <= r_idx + FCW'(1);
                r_rd_pend <= 1'b1;
            end else begin
                r_rd_pend <= 1'b0;
            end
        end
        // shift entries above the evicted one down by one place
        if (i_cmd.start_shift) begin
            r_evict   <= 1'b1;
            r_sh      <= r_old;
            r_sh_pend <= 1'b1;
        end else if (i_cmd.shift_step) begin
            r_sh <= AW'(r_sh + AW'(1));
        end
        if (i_cmd.load_out) begin
            if (q_op) begin
                if (FCW'(q_pos) < r_fill && 32'(q_pos) < 32'(MAX_ENTRIES)) begin
                    r_out <= {ram_rd, CNT_W'(r_fill), q_pos, OC_READ_OK};
                end else begin
                    r_out <= {ENT_W'(0), CNT_W'(r_fill), q_pos, OC_READ_NONE};
                end
            end else begin
                r_out <= {ent_new, CNT_W'(r_fill), POS_W'(done_slot),
                    r_found ? OC_UPDATED : (r_evict ? OC_EVICTED : OC_APPENDED)};
            end
        end
    end

    // ram layout already matches result field order from high end; reorder low-first
    logic [15:0] o_sid, o_user;
    logic [31:0] o_lat, o_lon, o_ts;
    logic [7:0]  o_bat;
    logic [3:0]  o_len;
    logic [95:0] o_nm;
    logic [13:0] o_hdr;
    assign {o_sid, o_user, o_lat, o_lon, o_bat, o_len, o_nm, o_ts, o_hdr} = r_out;
    assign o_res = OUT_TW'({o_ts, o_nm, o_len, o_bat, o_lon, o_lat, o_user, o_sid, o_hdr});
endmodule

>>> design/oldest_evict_station_table.sv
// channel   | dir | handshake          | payload
// s_axis    | in  | tvalid/tready      | tdata: request fields
// m_axis    | out | tvalid/tready      | tdata: result fields
// cfg       | in  | i_cfg_we           | i_cfg_data: capacity_limit
// An update scans the held entries for a match before it writes; an eviction at
// slot k also shifts the entries above it through the simple dual-port table RAM.
// One request at a time.
// Reset clears the count and sets the capacity to 30; the table needs no clear.
// A result held on m_axis blocks the next request until it is taken.
module oldest_evict_station_table #(
    parameter int MAX_ENTRIES = oest_pkg::MAX_ENTRIES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [oest_pkg::CAP_W-1:0]  i_cfg_data,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // operation, position, station_id, user_code, latitude, longitude, battery,
    // name_length, name_low, name_high, now_ms (low bit up)
    input  logic [oest_pkg::IN_TW-1:0]  s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // outcome, slot, entry_count, out_station_id, out_user_code, out_latitude,
    // out_longitude, out_battery, out_name_length, out_name_low,
    // out_name_high, out_last_seen (low bit up)
    output logic [oest_pkg::OUT_TW-1:0] m_axis_tdata
);
    import oest_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    oest_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_valid(s_axis_tvalid),
        .o_req_ready(s_axis_tready),
        .o_res_valid(m_axis_tvalid),
        .i_res_ready(m_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    oest_dp #(.MAX_ENTRIES(MAX_ENTRIES)) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_data(i_cfg_data),
        .i_req     (s_axis_tdata),
        .i_req_take(s_axis_tvalid && s_axis_tready),
        .i_cmd     (cmd),
        .o_stat    (stat),
        .o_res     (m_axis_tdata)
    );
endmodule

>>> design/oest_check.sv
module oest_check (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);
    // a result stalls until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped");
    // no new request while a result is pending
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("request taken with result pending");
    // outcome is a known code
    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[2:0] <= 3'd4)
        else $error("bad outcome");
    // accept leads to busy
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("ready after accept");
endmodule

bind oldest_evict_station_table oest_check u_oest_check (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata[7:0])
);
